>>> hdl/blsu_pkg.sv
// ----------------------------------------------------------------------------
// Bounded list with search: shared definitions
// Item types, mode and status codes, cell controls and the sequencer states.
// ----------------------------------------------------------------------------
package blsu_pkg;

    localparam int DEFAULT_CAPACITY    = 16;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    localparam logic [2:0] MODE_INS_HEAD   = 3'd0;
    localparam logic [2:0] MODE_INS_TAIL   = 3'd1;
    localparam logic [2:0] MODE_FIND       = 3'd2;
    localparam logic [2:0] MODE_REM_HEAD   = 3'd3;
    localparam logic [2:0] MODE_REM_SECOND = 3'd4;
    localparam logic [2:0] MODE_REM_LAST   = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [3:0]         position;
        logic signed [31:0] removed_value;
        logic [4:0]         length;
    } rsp_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     compare;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_FIND
    } seq_state_t;

endpackage

>>> hdl/bounded_list_with_search_unit.sv
// ----------------------------------------------------------------------------
// Bounded list with search: top level
// An ordered list of up to CAPACITY values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake         | Payload
//  req     | in        | req_valid/req_stall | req (mode, value)
//  rsp     | out       | rsp_valid/rsp_stall | rsp (status, found, position,
//          |           |                   |      removed_value, length)
//
//  Inserts and removes act in the accepting cycle: the cells concerned load
//  the key or take an entry from a neighbor, and the result is registered at once.
//  A find goes in order: the cells register their compare flags, then a
//  priority encoder over the flags of the held entries picks the first match.
//  Reset clears the entry count and the sequencer; entry contents are not reset.
//  A new item is taken while no find is in progress and the result register
//  is empty or being emptied, so a stalled result holds off the request side.
// ----------------------------------------------------------------------------
module bounded_list_with_search_unit #(
    parameter int CAPACITY    = blsu_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH = blsu_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  blsu_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output blsu_pkg::rsp_item_t rsp
);
    import blsu_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Entry count and sequencer.
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    seq_state_t       state_reg;
    seq_state_t       state_next;

    // Result register.
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    rsp_item_t rsp_reg;
    rsp_item_t rsp_next;

    logic                   accept;
    logic                   rsp_load;
    logic [VALUE_WIDTH-1:0] key;
    logic                   full;
    logic [IDX_W-1:0]       take_idx;
    logic                   take_ok;
    logic [VALUE_WIDTH-1:0] taken_value;

    // Cell row: controls in, entries and compare flags out.
    cell_ctrl_t             cell_ctrl [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0]    cell_hit;

    // First match among the held entries.
    logic                   first_found;
    logic [IDX_W-1:0]       first_idx;

    // The key is taken as an unsigned bit pattern of the list's own width.
    assign key  = VALUE_WIDTH'($unsigned(req.value));
    assign full = (occ_reg == CNT_W'(CAPACITY));

    assign req_stall = (state_reg == S_FIND) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;

    // Each cell receives its left neighbor's entry for a push at the head and
    // its right neighbor's entry to close a gap. The ends reuse the key and
    // their own entry.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cells
        logic [VALUE_WIDTH-1:0] left_w;
        logic [VALUE_WIDTH-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = key;
        end
        else
        begin : g_inner_left
            assign left_w = cell_entry[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_entry[g];
        end
        else
        begin : g_inner_right
            assign right_w = cell_entry[g+1];
        end

        blsu_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[g]),
            .key        (key),
            .left_data  (left_w),
            .right_data (right_w),
            .entry      (cell_entry[g]),
            .hit        (cell_hit[g])
        );
    end

    // Which entry a remove takes out, and whether the list is long enough.
    always_comb
    begin
        take_idx = '0;
        take_ok  = 1'b0;
        unique case (req.mode)
            MODE_REM_HEAD:
            begin
                take_idx = '0;
                take_ok  = (occ_reg != '0);
            end
            MODE_REM_SECOND:
            begin
                take_idx = IDX_W'(1);
                take_ok  = (occ_reg > CNT_W'(1));
            end
            MODE_REM_LAST:
            begin
                take_idx = IDX_W'(occ_reg - CNT_W'(1));
                take_ok  = (occ_reg != '0);
            end
            default:
            begin
                take_idx = '0;
                take_ok  = 1'b0;
            end
        endcase
    end

    assign taken_value = cell_entry[take_idx];

    // Priority encoder over the compare flags of held entries.
    always_comb
    begin
        first_found = 1'b0;
        first_idx   = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (!first_found && cell_hit[i] && (CNT_W'(i) < occ_reg))
            begin
                first_found = 1'b1;
                first_idx   = IDX_W'(i);
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.mode == MODE_FIND))
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: cell controls, entry count and the result.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_ctrl[i].op      = CELL_HOLD;
            cell_ctrl[i].compare = 1'b0;
        end
        occ_next = occ_reg;
        rsp_load = 1'b0;
        rsp_next = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_load = (req.mode != MODE_FIND);
                    unique case (req.mode)
                        MODE_INS_HEAD:
                        begin
                            if (full)
                            begin
                                rsp_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    cell_ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_TAKE_LEFT;
                                end
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        MODE_INS_TAIL:
                        begin
                            if (full)
                            begin
                                rsp_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (CNT_W'(i) == occ_reg)
                                    begin
                                        cell_ctrl[i].op = CELL_LOAD;
                                    end
                                end
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        MODE_FIND:
                        begin
                            for (int i = 0; i < CAPACITY; i++)
                            begin
                                cell_ctrl[i].compare = 1'b1;
                            end
                        end
                        MODE_REM_HEAD, MODE_REM_SECOND, MODE_REM_LAST:
                        begin
                            if (!take_ok)
                            begin
                                rsp_next.status = STATUS_SHORT;
                            end
                            else
                            begin
                                // Entries behind the taken one move one
                                // place toward the head.
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (IDX_W'(i) >= take_idx)
                                    begin
                                        cell_ctrl[i].op = CELL_TAKE_RIGHT;
                                    end
                                end
                                rsp_next.removed_value = 32'(taken_value);
                                occ_next = occ_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STATUS_OK;
                        end
                    endcase
                    rsp_next.length = 5'(occ_next);
                end
            end
            S_FIND:
            begin
                rsp_load          = 1'b1;
                rsp_next.status   = STATUS_OK;
                rsp_next.found    = first_found;
                rsp_next.position = 4'(first_idx);
                rsp_next.length   = 5'(occ_reg);
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    // The result register is free again once its item is taken.
    assign rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hdl/blsu_cell.sv
// ----------------------------------------------------------------------------
// Bounded list with search: list cell
// Holds one entry, moves it to or from its neighbors and compares it with a key.
// ----------------------------------------------------------------------------
module blsu_cell #(
    parameter int VALUE_WIDTH = blsu_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                   clk,
    input  blsu_pkg::cell_ctrl_t   ctrl,
    input  logic [VALUE_WIDTH-1:0] key,
    input  logic [VALUE_WIDTH-1:0] left_data,
    input  logic [VALUE_WIDTH-1:0] right_data,
    output logic [VALUE_WIDTH-1:0] entry,
    output logic                   hit
);
    import blsu_pkg::*;

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   hit_reg;

    always_comb
    begin
        unique case (ctrl.op)
            CELL_TAKE_LEFT:  entry_next = left_data;
            CELL_TAKE_RIGHT: entry_next = right_data;
            CELL_LOAD:       entry_next = key;
            default:         entry_next = entry_reg;
        endcase
    end

    // The match flag is sampled once per search and held for the encoder.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.compare)
        begin
            hit_reg <= (entry_reg == key);
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule
